// File: hdl/bvm_pkg.sv
// Shared types, widths and constants of the battery voltage monitor.
`default_nettype none

package bvm_pkg;

  // Field and register widths
  localparam int RAW_W      = 12;
  localparam int REF_W      = 12;
  localparam int DIV_W      = 14;
  localparam int ALPHA_W    = 9;
  localparam int MV_W       = 16;
  localparam int HYS_W      = 12;
  localparam int CNT_W      = 8;
  localparam int LVL_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // ADC full scale is an all-ones code, so the divide by it is a
  // reciprocal shift-and-add with one correction step.
  localparam int ADC_FS_BITS    = 12;
  localparam int ADC_FULL_SCALE = (1 << ADC_FS_BITS) - 1;

  localparam int GRACE_TICKS = 500;
  localparam int GRACE_W     = (GRACE_TICKS > 0) ? $clog2(GRACE_TICKS + 1) : 1;

  localparam int MV_SCALE   = 10000;
  localparam int PIN_PROD_W = RAW_W + REF_W;
  localparam int PIN_W      = REF_W;
  localparam int BAT_PROD_W = $clog2(((1 << REF_W) - 1) * MV_SCALE + 1);
  localparam int DCNT_W     = $clog2(BAT_PROD_W + 1);

  localparam int EMA_SHIFT  = 8;
  localparam int ALPHA_ONE  = 1 << EMA_SHIFT;
  localparam int EMA_ROUND  = 1 << (EMA_SHIFT - 1);
  localparam int EMA_PROD_W = ALPHA_W + MV_W;
  localparam int EMA_SUM_W  = EMA_PROD_W + 1;

  localparam int IN_TDATA_W  = ((RAW_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((MV_W + LVL_W + 7) / 8) * 8;

  typedef enum logic [LVL_W-1:0] {
    LVL_UNKNOWN = 2'd0,
    LVL_NORMAL  = 2'd1,
    LVL_WARN    = 2'd2,
    LVL_STOP    = 2'd3
  } lvl_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REF_MV     = 3'd0,
    CFG_DIV_RATIO  = 3'd1,
    CFG_ALPHA      = 3'd2,
    CFG_DISC_MV    = 3'd3,
    CFG_STOP_MV    = 3'd4,
    CFG_WARN_MV    = 3'd5,
    CFG_HYS_MV     = 3'd6,
    CFG_CONFIRM    = 3'd7
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PIN_MUL,
    ST_PIN_DIV,
    ST_BAT_MUL,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_EMA_MUL,
    ST_EMA_SUM,
    ST_CLASSIFY,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic load_sample;
    logic pin_mul;
    logic pin_div;
    logic bat_mul;
    logic div_start;
    logic ema_mul;
    logic ema_sum;
    logic classify;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// File: hdl/bvm_div.sv
// Restoring divider, one quotient bit per cycle, for battery millivolts.
`default_nettype none

module bvm_div
  import bvm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [BAT_PROD_W-1:0] dividend,
  input  wire logic [DIV_W-1:0]      divisor,
  output logic                       done,
  output logic [BAT_PROD_W-1:0]      quotient
);

  logic [DIV_W-1:0]      rem_r, rem_nxt;
  logic [BAT_PROD_W-1:0] quo_r, quo_nxt;
  logic [DCNT_W-1:0]     cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DIV_W:0]        shifted;
  logic                  fits;

  always_comb begin
    shifted  = {rem_r, quo_r[BAT_PROD_W-1]};
    fits     = (shifted >= {1'b0, divisor});
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = DCNT_W'(BAT_PROD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? DIV_W'(shifted - {1'b0, divisor}) : shifted[DIV_W-1:0];
      quo_nxt = {quo_r[BAT_PROD_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// File: hdl/bvm_dp.sv
// Datapath: scaling, EMA filter, classifier state, config and result registers.
`default_nettype none

module bvm_dp
  import bvm_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire dp_cmd_t                cmd,
  output dp_sts_t                     sts,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  // Configuration
  logic [REF_W-1:0]   ref_mv_r;
  logic [DIV_W-1:0]   div_ratio_r;
  logic [ALPHA_W-1:0] alpha_r;
  logic [MV_W-1:0]    disc_mv_r, stop_mv_r, warn_mv_r;
  logic [HYS_W-1:0]   hys_mv_r;
  logic [CNT_W-1:0]   confirm_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_mv_r      <= REF_W'(3300);
      div_ratio_r   <= DIV_W'(2500);
      alpha_r       <= ALPHA_W'(32);
      disc_mv_r     <= MV_W'(1000);
      stop_mv_r     <= MV_W'(9000);
      warn_mv_r     <= MV_W'(9500);
      hys_mv_r      <= HYS_W'(200);
      confirm_cnt_r <= CNT_W'(3);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_REF_MV:    ref_mv_r      <= cfg_wdata[REF_W-1:0];
        CFG_DIV_RATIO: div_ratio_r   <= cfg_wdata[DIV_W-1:0];
        CFG_ALPHA:     alpha_r       <= cfg_wdata[ALPHA_W-1:0];
        CFG_DISC_MV:   disc_mv_r     <= cfg_wdata[MV_W-1:0];
        CFG_STOP_MV:   stop_mv_r     <= cfg_wdata[MV_W-1:0];
        CFG_WARN_MV:   warn_mv_r     <= cfg_wdata[MV_W-1:0];
        CFG_HYS_MV:    hys_mv_r      <= cfg_wdata[HYS_W-1:0];
        CFG_CONFIRM:   confirm_cnt_r <= cfg_wdata[CNT_W-1:0];
      endcase
    end
  end

  // Scaling chain
  logic [RAW_W-1:0]       raw_r;
  logic [PIN_PROD_W-1:0]  pin_prod_r;
  logic [PIN_W-1:0]       pin_r;
  logic [BAT_PROD_W-1:0]  bat_prod_r;
  logic [MV_W-1:0]        now_r;
  logic [EMA_PROD_W-1:0]  new_prod_r;

  // Divide by all-ones full scale: estimate, then correct by at most one.
  logic [PIN_PROD_W:0]    fs_sum;
  logic [PIN_PROD_W:0]    fs_est;
  logic [PIN_PROD_W:0]    fs_back;
  logic [PIN_PROD_W:0]    fs_rem;
  logic [PIN_PROD_W:0]    fs_quo;

  always_comb begin
    fs_sum  = {1'b0, pin_prod_r} + (PIN_PROD_W+1)'(pin_prod_r >> ADC_FS_BITS);
    fs_est  = fs_sum >> ADC_FS_BITS;
    fs_back = (fs_est << ADC_FS_BITS) - fs_est;
    fs_rem  = {1'b0, pin_prod_r} - fs_back;
    fs_quo  = (fs_rem >= (PIN_PROD_W+1)'(ADC_FULL_SCALE)) ? fs_est + 1'b1 : fs_est;
  end

  logic                  div_done;
  logic [BAT_PROD_W-1:0] div_quo;

  bvm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (bat_prod_r),
    .divisor  (div_ratio_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Saturate battery millivolts; a zero ratio reads as full scale too
  logic [MV_W-1:0]    now_sat;
  logic [ALPHA_W-1:0] alpha_eff;
  logic [ALPHA_W-1:0] alpha_rest;

  always_comb begin
    if (div_ratio_r == '0 || div_quo > BAT_PROD_W'({MV_W{1'b1}})) begin
      now_sat = {MV_W{1'b1}};
    end else begin
      now_sat = div_quo[MV_W-1:0];
    end
    alpha_eff  = (alpha_r > ALPHA_W'(ALPHA_ONE)) ? ALPHA_W'(ALPHA_ONE) : alpha_r;
    alpha_rest = ALPHA_W'(ALPHA_ONE) - alpha_eff;
  end

  // Filter and classifier state
  logic [MV_W-1:0]    filt_r, filt_nxt;
  logic               primed_r, primed_nxt;
  logic [GRACE_W-1:0] grace_r, grace_nxt;
  logic [CNT_W-1:0]   confirm_r, confirm_nxt;
  lvl_t               lvl_r, lvl_nxt;
  logic [EMA_SUM_W-1:0] ema_sum;

  lvl_t               verdict;
  logic [MV_W:0]      mv_ext, stop_hys, warn_hys;
  logic [CNT_W-1:0]   confirm_inc;

  always_comb begin
    mv_ext   = {1'b0, filt_r};
    stop_hys = {1'b0, stop_mv_r} + (MV_W+1)'(hys_mv_r);
    warn_hys = {1'b0, warn_mv_r} + (MV_W+1)'(hys_mv_r);
    if (filt_r < disc_mv_r) begin
      verdict = LVL_UNKNOWN;
    end else begin
      unique case (lvl_r)
        LVL_STOP: verdict = (mv_ext >= stop_hys) ? LVL_WARN : LVL_STOP;
        LVL_WARN: begin
          if (filt_r <= stop_mv_r)    verdict = LVL_STOP;
          else if (mv_ext >= warn_hys) verdict = LVL_NORMAL;
          else                        verdict = LVL_WARN;
        end
        LVL_UNKNOWN, LVL_NORMAL: begin
          if (filt_r <= stop_mv_r)      verdict = LVL_STOP;
          else if (filt_r <= warn_mv_r) verdict = LVL_WARN;
          else                          verdict = LVL_NORMAL;
        end
      endcase
    end
    confirm_inc = (confirm_r < confirm_cnt_r) ? confirm_r + 1'b1 : confirm_r;
  end

  always_comb begin
    ema_sum     = EMA_SUM_W'(new_prod_r) + EMA_SUM_W'(alpha_rest) * EMA_SUM_W'(filt_r)
                + EMA_SUM_W'(EMA_ROUND);
    filt_nxt    = filt_r;
    primed_nxt  = primed_r;
    grace_nxt   = grace_r;
    confirm_nxt = confirm_r;
    lvl_nxt     = lvl_r;
    if (cmd.ema_sum) begin
      primed_nxt = 1'b1;
      filt_nxt   = primed_r ? ema_sum[EMA_SHIFT +: MV_W] : now_r;
    end
    if (cmd.classify) begin
      if (grace_r != '0) begin
        grace_nxt = grace_r - 1'b1;
        lvl_nxt   = LVL_UNKNOWN;
      end else if (verdict == LVL_STOP && lvl_r != LVL_STOP) begin
        confirm_nxt = confirm_inc;
        lvl_nxt     = (confirm_inc < confirm_cnt_r) ? LVL_WARN : LVL_STOP;
      end else if (verdict != LVL_STOP) begin
        confirm_nxt = '0;
        lvl_nxt     = verdict;
      end else begin
        lvl_nxt = verdict;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r    <= '0;
      primed_r  <= 1'b0;
      grace_r   <= GRACE_W'(GRACE_TICKS);
      confirm_r <= '0;
      lvl_r     <= LVL_UNKNOWN;
    end else begin
      filt_r    <= filt_nxt;
      primed_r  <= primed_nxt;
      grace_r   <= grace_nxt;
      confirm_r <= confirm_nxt;
      lvl_r     <= lvl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_sample) raw_r      <= in_tdata[RAW_W-1:0];
    if (cmd.pin_mul)     pin_prod_r <= PIN_PROD_W'(raw_r) * PIN_PROD_W'(ref_mv_r);
    if (cmd.pin_div)     pin_r      <= fs_quo[PIN_W-1:0];
    if (cmd.bat_mul)     bat_prod_r <= BAT_PROD_W'(pin_r) * BAT_PROD_W'(MV_SCALE);
    if (cmd.ema_mul) begin
      now_r      <= now_sat;
      new_prod_r <= EMA_PROD_W'(alpha_eff) * EMA_PROD_W'(now_sat);
    end
  end

  // Result register
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.emit) begin
      out_data_r <= OUT_TDATA_W'({lvl_r, filt_r});
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || out_tready;

endmodule

`default_nettype wire

// File: hdl/bvm_ctrl.sv
// Controller state machine that sequences one sample through the datapath.
`default_nettype none

module bvm_ctrl
  import bvm_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_tvalid,
  output logic         in_tready,
  output dp_cmd_t      cmd,
  input  wire dp_sts_t sts
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready       = 1'b1;
        cmd.load_sample = in_tvalid;
        if (in_tvalid) state_nxt = ST_PIN_MUL;
      end
      ST_PIN_MUL: begin
        cmd.pin_mul = 1'b1;
        state_nxt   = ST_PIN_DIV;
      end
      ST_PIN_DIV: begin
        cmd.pin_div = 1'b1;
        state_nxt   = ST_BAT_MUL;
      end
      ST_BAT_MUL: begin
        cmd.bat_mul = 1'b1;
        state_nxt   = ST_DIV_START;
      end
      ST_DIV_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (sts.div_done) state_nxt = ST_EMA_MUL;
      end
      ST_EMA_MUL: begin
        cmd.ema_mul = 1'b1;
        state_nxt   = ST_EMA_SUM;
      end
      ST_EMA_SUM: begin
        cmd.ema_sum = 1'b1;
        state_nxt   = ST_CLASSIFY;
      end
      ST_CLASSIFY: begin
        cmd.classify = 1'b1;
        state_nxt    = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/battery_voltage_monitor_core.sv
// Top level of the battery voltage monitor: controller plus datapath.
//
//  channel  | ports                       | item contents (lowest bit first)
//  ---------+-----------------------------+-----------------------------------
//  input    | in_tvalid/in_tready/tdata   | raw_sample[11:0], zero pad to 16
//  result   | out_tvalid/out_tready/tdata | battery_mv[15:0], battery_state[1:0],
//           |                             | zero pad to 24
//  config   | cfg_we/cfg_index/cfg_wdata  | register index 0..7, value in low bits
//
// From acceptance to result an item is scaled, divided by the divider ratio in a
// restoring division, filtered and classified; the division is the longest step.
// One item is in flight at a time; the next is taken while the result waits.
// rst_n is synchronous, active low, and restores the register defaults,
// a cleared filter, an unknown state and the full start-up grace count.
// A stalled result holds the controller in its last step until taken.
`default_nettype none

module battery_voltage_monitor_core
  import bvm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // raw_sample[11:0]
  input  wire logic [IN_TDATA_W-1:0] in_tdata,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // battery_mv[15:0], battery_state[17:16]
  output logic [OUT_TDATA_W-1:0]     out_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequence the scaling, filter and classifier steps
  bvm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Hold config, arithmetic, filter state and the result register
  bvm_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

endmodule

`default_nettype wire
